FILE: sv/chunk_reassembly_buffer_assert.svh
// Assertion macros for the chunk reassembly buffer.
`ifndef CHUNK_REASSEMBLY_BUFFER_ASSERT_SVH
`define CHUNK_REASSEMBLY_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/crb_pkg.sv
package crb_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic REQ_PAYLOAD = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_BAD  = 2'd2,
    STAT_DONE = 2'd3
  } status_t;

  // input item fields, highest bits first
  typedef struct packed {
    logic [13:0] read_address;
    logic [7:0]  data_byte;
    logic [9:0]  byte_offset;
    logic [7:0]  frag_total;
    logic [7:0]  frag_id;
  } in_data_t;

  // result fields other than the read byte, carried past the RAM read
  typedef struct packed {
    logic        read_valid;
    logic [14:0] message_length;
    logic [4:0]  chunks_held;
    logic        complete;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [14:0] message_length;
    logic [4:0]  chunks_held;
    logic        complete;
    status_t     status;
  } out_data_t;

endpackage

FILE: sv/chunk_reassembly_buffer.sv
// Rebuilds one message of up to MAX_FRAGS chunks of CHUNK_BYTES bytes each from a
// stream of payload bytes; a packet is judged at its first byte (bad chunk or
// duplicate is dropped), kept bytes land in a single-port-write RAM at
// frag_id*CHUNK_BYTES+byte_offset, and read requests fetch stored bytes once all
// expected chunks are held. One item is taken per cycle while the output drains.
// The RAM read and the result register load on the accepting edge and the output
// register loads from them once it is empty or being taken, so a result passes
// through both registers before it is offered. The two stages hold two items;
// once both are full, a low m_tready holds s_tready low. s_tready is low during
// reset. No clearing pass runs after reset; bytes never written read as undefined.
module chunk_reassembly_buffer
  import crb_pkg::*;
#(
  parameter int CHUNK_BYTES = 1024,
  parameter int MAX_FRAGS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // frag_id[7:0], frag_total[15:8], byte_offset[25:16], data_byte[33:26],
  // read_address[47:34]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // req_type
  input  logic                  s_tlast,   // last_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[1:0], complete[2], chunks_held[7:3], message_length[22:8],
  // read_byte[30:23], read_valid[31]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int StoreSize = MAX_FRAGS * CHUNK_BYTES;
  localparam int AW = $clog2(StoreSize);
  localparam int IW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int CW = $clog2(MAX_FRAGS + 1);
  localparam int TW = $clog2(StoreSize + 1);

  in_data_t in_d;
  logic     s_acc;
  logic     o_load;

  logic [MAX_FRAGS-1:0]  held_map, held_map_next;
  logic [CW-1:0]         held_count, held_count_next;
  logic [CW-1:0]         expected_count, expected_count_next;
  logic [TW-1:0]         total_bytes, total_bytes_next;
  logic                  packet_keep, packet_keep_next;
  logic                  in_packet, in_packet_next;
  logic [IW-1:0]         keep_id, keep_id_next;

  logic          p_vld;
  res_t          p_res;
  res_t          res_next;
  out_data_t     o_data;
  logic          o_vld;

  logic [7:0]    limit;
  logic          bad, dup, keep_now;
  logic [IW-1:0] id_now;
  logic [31:0]   len;
  logic          ram_we, ram_re, rd_ok;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   waddr_w, raddr_w;
  logic [7:0]    ram_rdata;
  status_t       status;
  logic          cmp_next;

  assign in_d   = in_data_t'(s_tdata);
  assign o_load = p_vld && (!o_vld || m_tready);
  assign s_tready = !rst && (!p_vld || o_load);
  assign s_acc  = s_tvalid && s_tready;

  always_comb begin
    held_map_next       = held_map;
    held_count_next     = held_count;
    expected_count_next = expected_count;
    total_bytes_next    = total_bytes;
    packet_keep_next    = packet_keep;
    in_packet_next      = in_packet;
    keep_id_next        = keep_id;
    status              = STAT_OK;
    limit    = (expected_count != '0) ? 8'(expected_count) : in_d.frag_total;
    bad      = (in_d.frag_total == 8'd0) || (in_d.frag_total > 8'(MAX_FRAGS)) ||
               (in_d.frag_id >= limit);
    dup      = held_map[in_d.frag_id[IW-1:0]];
    keep_now = packet_keep;
    id_now   = keep_id;
    len      = (32'(in_d.byte_offset) + 32'd1 > 32'(CHUNK_BYTES)) ? 32'(CHUNK_BYTES) :
               32'(in_d.byte_offset) + 32'd1;
    waddr_w  = 32'(keep_id) * 32'(CHUNK_BYTES) + 32'(in_d.byte_offset);
    ram_we   = 1'b0;
    raddr_w  = 32'(in_d.read_address);
    rd_ok    = 1'b0;
    ram_re   = 1'b0;
    if (s_acc) begin
      if (s_tuser == REQ_READ) begin
        rd_ok  = (expected_count != '0) && (held_count == expected_count) &&
                 (raddr_w < 32'(total_bytes)) && (raddr_w < 32'(StoreSize));
        ram_re = rd_ok;
      end else begin
        if (!in_packet) begin
          if (bad) begin
            status   = STAT_BAD;
            keep_now = 1'b0;
          end else if (dup) begin
            status   = STAT_DUP;
            keep_now = 1'b0;
          end else begin
            keep_now = 1'b1;
            id_now   = in_d.frag_id[IW-1:0];
            if (expected_count == '0) begin
              expected_count_next = CW'(in_d.frag_total);
            end
          end
        end
        waddr_w = 32'(id_now) * 32'(CHUNK_BYTES) + 32'(in_d.byte_offset);
        ram_we  = keep_now && (32'(in_d.byte_offset) < 32'(CHUNK_BYTES));
        keep_id_next = id_now;
        if (s_tlast) begin
          if (keep_now) begin
            held_map_next[id_now] = 1'b1;
            held_count_next       = held_count + CW'(1);
            total_bytes_next      = total_bytes + TW'(len);
            if (held_count_next == expected_count_next) begin
              status = STAT_DONE;
            end
          end
          packet_keep_next = 1'b0;
          in_packet_next   = 1'b0;
        end else begin
          packet_keep_next = keep_now;
          in_packet_next   = 1'b1;
        end
      end
    end
    ram_waddr = waddr_w[AW-1:0];
    ram_raddr = raddr_w[AW-1:0];
    cmp_next  = (expected_count_next != '0) && (held_count_next == expected_count_next);
    res_next.status         = status;
    res_next.complete       = cmp_next;
    res_next.chunks_held    = 5'(held_count_next);
    res_next.message_length = 15'(total_bytes_next);
    res_next.read_valid     = rd_ok;
  end

  crb_ram #(
    .WIDTH(8),
    .DEPTH(StoreSize)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_d.data_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_map       <= '0;
      held_count     <= '0;
      expected_count <= '0;
      total_bytes    <= '0;
      packet_keep    <= 1'b0;
      in_packet      <= 1'b0;
      keep_id        <= '0;
      p_vld          <= 1'b0;
      o_vld          <= 1'b0;
    end else begin
      held_map       <= held_map_next;
      held_count     <= held_count_next;
      expected_count <= expected_count_next;
      total_bytes    <= total_bytes_next;
      packet_keep    <= packet_keep_next;
      in_packet      <= in_packet_next;
      keep_id        <= keep_id_next;
      if (s_acc) begin
        p_vld <= 1'b1;
      end else if (o_load) begin
        p_vld <= 1'b0;
      end
      if (o_load) begin
        o_vld <= 1'b1;
      end else if (m_tready) begin
        o_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      p_res <= res_next;
    end
    if (o_load) begin
      o_data.status         <= p_res.status;
      o_data.complete       <= p_res.complete;
      o_data.chunks_held    <= p_res.chunks_held;
      o_data.message_length <= p_res.message_length;
      o_data.read_valid     <= p_res.read_valid;
      o_data.read_byte      <= p_res.read_valid ? ram_rdata : 8'd0;
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = OUT_DATA_W'(o_data);

`include "chunk_reassembly_buffer_assert.svh"

  `CRB_ASSERT_NOW(a_count_map, 1'b1, $countones(held_map) == int'(held_count), "count off")
  `CRB_ASSERT_NEXT(a_expect_fixed, expected_count != '0, $stable(expected_count), "moved")
  `CRB_ASSERT_NEXT(a_accept_fills, s_acc, p_vld, "accepted item lost")
  `CRB_ASSERT_NOW(a_done_cmp, p_vld && p_res.status == STAT_DONE, p_res.complete, "bad done")

endmodule

FILE: sv/crb_ram.sv
module crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/chunk_reassembly_buffer_tb.sv
`timescale 1ns / 1ps

module chunk_reassembly_buffer_tb
  import crb_pkg::*;
();

  localparam int CHUNK_BYTES = 1024;
  localparam int MAX_FRAGS   = 16;
  localparam int STORE_SIZE  = CHUNK_BYTES * MAX_FRAGS;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_STALL   = 400;

  typedef struct {
    logic      req;
    in_data_t  d;
    logic      last;
    out_data_t res;
  } frag_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  chunk_reassembly_buffer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // reassembly shadow state
  logic [15:0] held_bits = '0;
  logic [4:0]  held_num = '0;
  logic [4:0]  want_num = '0;
  logic [14:0] msg_len = '0;
  logic        pkt_keep = 1'b0;
  logic        pkt_open = 1'b0;
  logic [3:0]  pkt_id = '0;
  logic [7:0]  msg_mem [STORE_SIZE];
  bit          msg_written [STORE_SIZE];

  frag_item_t  pending_items[$];
  out_data_t   expected_results[$];
  frag_item_t  cur;
  out_data_t   got;
  out_data_t   want;
  int          total_items = 0;
  int          sent = 0;
  int          phase = 0;
  int          errors = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          stall_done = 1'b0;

  function automatic bit msg_done();
    return want_num != 0 && held_num == want_num;
  endfunction

  task automatic reassemble_step(input logic req, input in_data_t d, input logic last,
                                 output out_data_t r);
    int limit;
    int addr;
    r = '0;
    r.status = STAT_OK;
    if (req == REQ_READ) begin
      if (msg_done() && int'(d.read_address) < int'(msg_len)) begin
        r.read_valid = 1'b1;
        r.read_byte = msg_mem[d.read_address];
      end
    end else begin
      if (!pkt_open) begin
        limit = (want_num != 0) ? int'(want_num) : int'(d.frag_total);
        pkt_keep = 1'b0;
        if (d.frag_total == 0 || int'(d.frag_total) > MAX_FRAGS ||
            int'(d.frag_id) >= limit) begin
          r.status = STAT_BAD;
        end else if (held_bits[d.frag_id[3:0]]) begin
          r.status = STAT_DUP;
        end else begin
          pkt_keep = 1'b1;
          pkt_id = d.frag_id[3:0];
          if (want_num == 0) want_num = d.frag_total[4:0];
        end
      end
      if (pkt_keep && int'(d.byte_offset) < CHUNK_BYTES) begin
        addr = int'(pkt_id) * CHUNK_BYTES + int'(d.byte_offset);
        if (addr < STORE_SIZE) begin
          msg_mem[addr] = d.data_byte;
          msg_written[addr] = 1'b1;
        end
      end
      if (last) begin
        if (pkt_keep) begin
          held_bits[pkt_id] = 1'b1;
          held_num = held_num + 5'd1;
          msg_len = msg_len + 15'((int'(d.byte_offset) + 1 > CHUNK_BYTES) ?
                                  CHUNK_BYTES : int'(d.byte_offset) + 1);
          if (msg_done()) r.status = STAT_DONE;
        end
        pkt_keep = 1'b0;
        pkt_open = 1'b0;
      end else begin
        pkt_open = 1'b1;
      end
    end
    r.complete = msg_done();
    r.chunks_held = held_num;
    r.message_length = msg_len;
  endtask

  task automatic add_item(input logic req, input int id, input int cnt, input int off,
                          input int data, input logic last, input int raddr);
    frag_item_t it;
    it.req = req;
    it.last = last;
    it.d.frag_id = 8'(id);
    it.d.frag_total = 8'(cnt);
    it.d.byte_offset = 10'(off);
    it.d.data_byte = 8'(data);
    it.d.read_address = 14'(raddr);
    reassemble_step(it.req, it.d, it.last, it.res);
    pending_items.push_back(it);
  endtask

  // never aims a valid read at a byte that was never stored
  task automatic add_read();
    int raddr;
    int tries;
    if (msg_done() && msg_len != 0 && $urandom_range(0, 4) != 0)
      raddr = $urandom_range(0, int'(msg_len) - 1);
    else
      raddr = $urandom_range(0, STORE_SIZE - 1);
    tries = 0;
    while (msg_done() && raddr < int'(msg_len) && !msg_written[raddr] && tries < 16) begin
      raddr = $urandom_range(0, int'(msg_len) - 1);
      tries++;
    end
    if (msg_done() && raddr < int'(msg_len) && !msg_written[raddr]) begin
      raddr = 0;
      while (!msg_written[raddr]) raddr++;
    end
    add_item(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 1023), $urandom_range(0, 255), 1'($urandom_range(0, 1)),
             raddr);
  endtask

  task automatic add_packet(input int id, input int cnt, input int len);
    int off;
    bit is_last;
    for (int i = 0; i < len; i++) begin
      is_last = (i == len - 1);
      off = i;
      if (is_last && $urandom_range(0, 9) == 0) off = $urandom_range(i, 1023);
      if (i > 0 && $urandom_range(0, 9) == 0) add_read();
      if (i > 0 && $urandom_range(0, 9) < 3)
        add_item(REQ_PAYLOAD, $urandom_range(0, 255), $urandom_range(0, 255), off,
                 $urandom_range(0, 255), is_last, $urandom_range(0, STORE_SIZE - 1));
      else
        add_item(REQ_PAYLOAD, id, cnt, off, $urandom_range(0, 255), is_last,
                 $urandom_range(0, STORE_SIZE - 1));
    end
  endtask

  task automatic add_new_chunk();
    int id;
    id = $urandom_range(0, MAX_FRAGS - 1);
    while (held_bits[id]) id = $urandom_range(0, MAX_FRAGS - 1);
    add_packet(id, $urandom_range(1, MAX_FRAGS), $urandom_range(1, 24));
  endtask

  task automatic add_dup_chunk();
    int id;
    id = $urandom_range(0, MAX_FRAGS - 1);
    while (!held_bits[id]) id = $urandom_range(0, MAX_FRAGS - 1);
    add_packet(id, $urandom_range(1, MAX_FRAGS), $urandom_range(1, 8));
  endtask

  task automatic add_bad_chunk();
    case ($urandom_range(0, 2))
      0: add_packet($urandom_range(0, 255), 0, $urandom_range(1, 6));
      1: add_packet($urandom_range(0, 255), $urandom_range(MAX_FRAGS + 1, 255),
                    $urandom_range(1, 6));
      default: add_packet($urandom_range(MAX_FRAGS, 255), $urandom_range(1, MAX_FRAGS),
                          $urandom_range(1, 6));
    endcase
  endtask

  function automatic void check_field(string name, int expv, int gotv);
    if (expv != gotv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(cur.res);
        sent++;
      end
      phase <= (sent < total_items / 3) ? 0 : (sent < 2 * total_items / 3) ? 1 : 2;
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 &&
            $urandom_range(0, 99) >= (phase == 0 ? 24 : phase == 1 ? 64 : 0)) begin
          cur = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= cur.d;
          s_tuser <= cur.req;
          s_tlast <= cur.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          $error("result with no expectation pending: %h", m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(want.status), int'(got.status));
          check_field("complete", int'(want.complete), int'(got.complete));
          check_field("chunks_held", int'(want.chunks_held), int'(got.chunks_held));
          check_field("message_length", int'(want.message_length), int'(got.message_length));
          check_field("read_byte", int'(want.read_byte), int'(got.read_byte));
          check_field("read_valid", int'(want.read_valid), int'(got.read_valid));
        end
      end
      if (phase == 2 && !stall_done) begin
        stall_left = LONG_STALL;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= (phase == 0 ? 64 : phase == 1 ? 24 : 0));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int r;
    // directed: bad counts and ids before the count is known, extremes, duplicates
    add_item(REQ_READ, 0, 0, 0, 0, 1'b0, 0);
    add_item(REQ_PAYLOAD, 0, 0, 0, 'h00, 1'b1, 0);
    add_item(REQ_PAYLOAD, 0, MAX_FRAGS + 1, 0, 'h11, 1'b1, 0);
    add_item(REQ_PAYLOAD, 0, 255, 0, 'h22, 1'b1, 16383);
    add_item(REQ_PAYLOAD, 5, 3, 0, 'h33, 1'b1, 0);
    add_item(REQ_PAYLOAD, 255, MAX_FRAGS, 0, 'h44, 1'b0, 0);
    add_item(REQ_PAYLOAD, 0, 1, 1, 'h55, 1'b1, 0);
    add_item(REQ_PAYLOAD, MAX_FRAGS - 1, MAX_FRAGS, 1023, 'hFF, 1'b1, 0);
    add_item(REQ_PAYLOAD, MAX_FRAGS - 1, 5, 0, 'hAA, 1'b0, 0);
    add_item(REQ_PAYLOAD, MAX_FRAGS - 1, 5, 1, 'hBB, 1'b1, 0);
    add_item(REQ_PAYLOAD, 0, MAX_FRAGS, 0, 'h00, 1'b0, 0);
    add_item(REQ_READ, 255, 255, 1023, 'hFF, 1'b1, 16383);
    add_item(REQ_PAYLOAD, 255, 0, 1, 'hFF, 1'b1, 16383);
    add_item(REQ_PAYLOAD, MAX_FRAGS, MAX_FRAGS, 0, 'h66, 1'b1, 0);
    add_item(REQ_PAYLOAD, 0, 1, 0, 'h77, 1'b1, 0);
    add_item(REQ_READ, 0, 0, 0, 0, 1'b0, 1023);

    while (pending_items.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (!msg_done()) begin
        if (r < 8) add_new_chunk();
        else if (r < 28) add_dup_chunk();
        else if (r < 43) add_bad_chunk();
        else add_read();
      end else begin
        if (r < 70) add_read();
        else if (r < 85) add_dup_chunk();
        else add_bad_chunk();
      end
    end
    while (!msg_done()) add_new_chunk();
    repeat (40) add_read();
    total_items = pending_items.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/crb_pkg.sv
sv/crb_ram.sv
sv/chunk_reassembly_buffer.sv
sim/chunk_reassembly_buffer_tb.sv
